// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed: always");

// when the antecedent holds, the consequent must hold on the same edge
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

// ===== rtl/swlpd_pkg.sv =====
package swlpd_pkg;

  localparam logic [31:0] SyncWord  = 32'h0000_01A5;
  localparam logic [3:0]  HeaderSkip = 4'd9;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_SKIP9 = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] packet_length;
    logic [7:0]  out_byte;
    kind_t       kind;
    logic        last_of_packet;
  } result_t;

endpackage

// ===== rtl/sync_word_length_prefixed_deframer.sv =====
// channel | dir | fields (tdata / tuser / tlast)
// in_     | in  | tdata[7:0] in_byte ; tlast end_of_stream
// out_    | out | tdata[7:0] out_byte, tdata[23:8] packet_length ;
//         |     | tuser[1:0] kind ; tlast last_of_packet
//
// one byte per clock while in_tready is high: each request is decoded
// in the cycle it is taken and the result lands on the same edge in the
// output register, or in the skid if the output is held; the two-entry
// output keeps in_tready up while one result waits, down when both full
// reset (rst_n low, synchronous) returns to the sync hunt, outputs empty
`include "assert_macros.svh"

module sync_word_length_prefixed_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] packet_length
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_packet
);
  import swlpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] sync_shift_r, sync_shift_nxt;
  logic [3:0]  skip_count_r, skip_count_nxt;
  logic [15:0] length_hold_r, length_hold_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;

  logic        out_vld_r, out_vld_nxt;
  result_t     out_r, out_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  result_t     skid_r, skid_nxt;

  logic        in_fire;
  logic        res_vld;
  result_t     res;
  logic [3:0]  skip_inc;

  assign in_tready = ~skid_vld_r;
  assign in_fire   = in_tvalid & in_tready;
  assign skip_inc  = skip_count_r + 4'd1;

  always_comb begin
    phase_nxt       = phase_r;
    sync_shift_nxt  = sync_shift_r;
    skip_count_nxt  = skip_count_r;
    length_hold_nxt = length_hold_r;
    bytes_left_nxt  = bytes_left_r;
    res_vld         = 1'b0;
    res             = '0;
    if (in_fire) begin
      if (in_tlast) begin
        phase_nxt          = PH_HUNT;
        sync_shift_nxt     = '1;
        skip_count_nxt     = '0;
        length_hold_nxt    = '0;
        bytes_left_nxt     = '0;
        res_vld            = 1'b1;
        res.kind           = KIND_ERROR;
        res.last_of_packet = 1'b1;
      end else begin
        case (phase_r)
          PH_SKIP1: begin
            phase_nxt = PH_LENLO;
          end
          PH_LENLO: begin
            length_hold_nxt = {8'h00, in_tdata};
            phase_nxt       = PH_LENHI;
          end
          PH_LENHI: begin
            length_hold_nxt = {in_tdata, length_hold_r[7:0]};
            skip_count_nxt  = '0;
            phase_nxt       = PH_SKIP9;
          end
          PH_SKIP9: begin
            if (skip_inc < HeaderSkip) begin
              skip_count_nxt = skip_inc;
            end else begin
              skip_count_nxt = '0;
              if (length_hold_r == 16'd0) begin
                phase_nxt          = PH_HUNT;
                sync_shift_nxt     = '1;
                length_hold_nxt    = '0;
                bytes_left_nxt     = '0;
                res_vld            = 1'b1;
                res.kind           = KIND_EMPTY;
                res.last_of_packet = 1'b1;
              end else begin
                bytes_left_nxt = length_hold_r;
                phase_nxt      = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            res_vld           = 1'b1;
            res.kind          = KIND_DATA;
            res.out_byte      = in_tdata;
            res.packet_length = length_hold_r;
            if (bytes_left_r <= 16'd1) begin
              res.last_of_packet = 1'b1;
              phase_nxt          = PH_HUNT;
              sync_shift_nxt     = '1;
              skip_count_nxt     = '0;
              length_hold_nxt    = '0;
              bytes_left_nxt     = '0;
            end else begin
              bytes_left_nxt = bytes_left_r - 16'd1;
            end
          end
          default: begin
            // hunting, also catches unused codes
            sync_shift_nxt = {sync_shift_r[23:0], in_tdata};
            phase_nxt      = (sync_shift_nxt == SyncWord) ? PH_SKIP1 : PH_HUNT;
          end
        endcase
      end
    end
  end

  // output register with skid entry behind it
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = res_vld;
        out_nxt     = res;
      end
    end else if (res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      sync_shift_r  <= '1;
      skip_count_r  <= '0;
      length_hold_r <= '0;
      bytes_left_r  <= '0;
      out_vld_r     <= 1'b0;
      skid_vld_r    <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      sync_shift_r  <= sync_shift_nxt;
      skip_count_r  <= skip_count_nxt;
      length_hold_r <= length_hold_nxt;
      bytes_left_r  <= bytes_left_nxt;
      out_vld_r     <= out_vld_nxt;
      skid_vld_r    <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.packet_length, out_r.out_byte};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last_of_packet;

  // skid only fills behind a held output
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_vld_r, out_vld_r)
  // payload counter is live only while passing payload
  `ASSERT_IMPLIES(a_count_idle, clk, rst_n, phase_r != PH_DATA, bytes_left_r == 16'd0)
  `ASSERT_IMPLIES(a_count_range, clk, rst_n, phase_r == PH_DATA,
    (bytes_left_r != 16'd0) && (bytes_left_r <= length_hold_r))
  `ASSERT_ALWAYS(a_skip_range, clk, rst_n, skip_count_r < HeaderSkip)

endmodule
